>>> hdl/dhd_pkg.sv
// dhd_pkg: shared constants and types for the detection head decoder.
// Field widths, register map, reset values and fixed-point formats.
// No dependencies.
`timescale 1ns / 1ps

package dhd_pkg;

  // Default sizing
  localparam int MAX_CLASSES_DEF = 1024;
  localparam int MAX_PREDS_DEF   = 16384;

  // Port field widths
  localparam int VALUE_W      = 16;
  localparam int BOX_XY_W     = 12;
  localparam int BOX_WH_W     = 13;
  localparam int SCORE_W      = 16;
  localparam int CLASS_ID_W   = 10;
  localparam int PRED_INDEX_W = 14;

  // Configuration register widths
  localparam int THR_W       = 16;
  localparam int PAD_W       = 11;
  localparam int INV_SCALE_W = 24;
  localparam int IMG_W       = 13;
  localparam int CLS_CNT_W   = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_PAD_LEFT        = 3'd1,
    REG_PAD_TOP         = 3'd2,
    REG_INV_SCALE       = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5,
    REG_CLASS_COUNT     = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [THR_W-1:0]       THR_RST       = 16'd16384;
  localparam logic [PAD_W-1:0]       PAD_RST       = 11'd0;
  localparam logic [INV_SCALE_W-1:0] INV_SCALE_RST = 24'd65536;
  localparam logic [IMG_W-1:0]       IMG_SIZE_RST  = 13'd640;
  localparam logic [CLS_CNT_W-1:0]   CLS_CNT_RST   = 11'd1;

  // Largest image extent in pixels
  localparam logic [IMG_W-1:0] IMG_SIZE_MAX = 13'd4096;

  // Fixed-point datapath: box fields Q12.4, doubled -> Q.5, times Q8.16 -> 2^-21 pixel
  localparam int FRAC_BITS = 21;
  localparam int NUM_W     = 18;  // signed 2*c - s - 32*pad
  localparam int LO_W      = 42;  // signed corner product
  localparam int EXT_W     = 41;  // unsigned size product
  localparam int LOC_W     = 33;  // clamped corner, below 4096 * 2^21
  localparam int ROOM_W    = 34;  // up to 4096 * 2^21

endpackage

>>> hdl/detection_head_decode_top.sv
// detection_head_decode_top: streaming anchor-free box decoder with letterbox undo.
// Depends on dhd_pkg (widths, register map, reset values).
`timescale 1ns / 1ps

// One detector value is taken per clock while in_ready is high: cx, cy, w, h, then
// class_count scores for each prediction. Every value is a single-cycle transfer; the
// block keeps accepting while a decoded box waits at the output, and in_ready only drops
// when all four pipeline stages hold results nobody has taken yet. When the last score of
// a prediction is accepted and its best score reaches score_threshold, the prediction
// register loads on that same edge and the box then moves through the multiplier stage,
// clamp stage and output register to the output. The pipeline is split around the 18x25
// and 17x24 multipliers and the clamp/limit compares that follow them.
// Predictions that fail the threshold produce nothing but still advance pred_index.
// Configuration registers must only be written while no prediction is in flight.
module detection_head_decode_top #(
  parameter int MAX_CLASSES = dhd_pkg::MAX_CLASSES_DEF,
  parameter int MAX_PREDS   = dhd_pkg::MAX_PREDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [dhd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dhd_pkg::CFG_DATA_W-1:0]       cfg_data,
  // value stream
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dhd_pkg::VALUE_W-1:0]          in_value,
  // decoded boxes
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dhd_pkg::BOX_XY_W-1:0]         out_box_x,
  output logic [dhd_pkg::BOX_XY_W-1:0]         out_box_y,
  output logic [dhd_pkg::BOX_WH_W-1:0]         out_box_width,
  output logic [dhd_pkg::BOX_WH_W-1:0]         out_box_height,
  output logic [dhd_pkg::SCORE_W-1:0]          out_score,
  output logic [dhd_pkg::CLASS_ID_W-1:0]       out_class_id,
  output logic [dhd_pkg::PRED_INDEX_W-1:0]     out_pred_index
);

  localparam int POS_W  = $clog2(MAX_CLASSES + 4);
  localparam int PRED_W = $clog2(MAX_PREDS);

  localparam logic [POS_W-1:0] FP_CX    = POS_W'(0);
  localparam logic [POS_W-1:0] FP_CY    = POS_W'(1);
  localparam logic [POS_W-1:0] FP_W     = POS_W'(2);
  localparam logic [POS_W-1:0] FP_H     = POS_W'(3);
  localparam logic [POS_W-1:0] FP_SCORE = POS_W'(4);

  localparam int VW  = dhd_pkg::VALUE_W;
  localparam int FB  = dhd_pkg::FRAC_BITS;
  localparam int NW  = dhd_pkg::NUM_W;
  localparam int LW  = dhd_pkg::LO_W;
  localparam int EW  = dhd_pkg::EXT_W;
  localparam int CW  = dhd_pkg::LOC_W;
  localparam int RW  = dhd_pkg::ROOM_W;
  localparam int IW  = dhd_pkg::IMG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [dhd_pkg::THR_W-1:0]       thr_r;
  logic [dhd_pkg::PAD_W-1:0]       pad_left_r;
  logic [dhd_pkg::PAD_W-1:0]       pad_top_r;
  logic [dhd_pkg::INV_SCALE_W-1:0] inv_scale_r;
  logic [IW-1:0]                   img_w_r;
  logic [IW-1:0]                   img_h_r;
  logic [dhd_pkg::CLS_CNT_W-1:0]   cls_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= dhd_pkg::THR_RST;
      pad_left_r  <= dhd_pkg::PAD_RST;
      pad_top_r   <= dhd_pkg::PAD_RST;
      inv_scale_r <= dhd_pkg::INV_SCALE_RST;
      img_w_r     <= dhd_pkg::IMG_SIZE_RST;
      img_h_r     <= dhd_pkg::IMG_SIZE_RST;
      cls_cnt_r   <= dhd_pkg::CLS_CNT_RST;
    end else if (cfg_we) begin
      case (dhd_pkg::cfg_reg_t'(cfg_index))
        dhd_pkg::REG_SCORE_THRESHOLD: thr_r       <= cfg_data[dhd_pkg::THR_W-1:0];
        dhd_pkg::REG_PAD_LEFT:        pad_left_r  <= cfg_data[dhd_pkg::PAD_W-1:0];
        dhd_pkg::REG_PAD_TOP:         pad_top_r   <= cfg_data[dhd_pkg::PAD_W-1:0];
        dhd_pkg::REG_INV_SCALE:       inv_scale_r <= cfg_data[dhd_pkg::INV_SCALE_W-1:0];
        dhd_pkg::REG_IMAGE_WIDTH:     img_w_r     <= cfg_data[IW-1:0];
        dhd_pkg::REG_IMAGE_HEIGHT:    img_h_r     <= cfg_data[IW-1:0];
        dhd_pkg::REG_CLASS_COUNT:     cls_cnt_r   <= cfg_data[dhd_pkg::CLS_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective class count, saturated to [1, MAX_CLASSES]
  logic [POS_W-1:0] ncls;
  always_comb begin
    if (cls_cnt_r == '0) begin
      ncls = POS_W'(1);
    end else if (32'(cls_cnt_r) > 32'(MAX_CLASSES)) begin
      ncls = POS_W'(MAX_CLASSES);
    end else begin
      ncls = POS_W'(cls_cnt_r);
    end
  end

  // Image extents, saturated to [1, 4096]
  function automatic logic [IW-1:0] sat_img(input logic [IW-1:0] v);
    logic [IW-1:0] r;
    if (v == '0) begin
      r = IW'(1);
    end else if (v > dhd_pkg::IMG_SIZE_MAX) begin
      r = dhd_pkg::IMG_SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [IW-1:0] lim_x;
  logic [IW-1:0] lim_y;
  assign lim_x = sat_img(img_w_r);
  assign lim_y = sat_img(img_h_r);

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage loads when empty or when it drains
  // ---------------------------------------------------------------------------
  logic a_vld_r, b_vld_r, c_vld_r, out_vld_r;
  logic a_rdy, b_rdy, c_rdy, d_rdy;

  assign d_rdy    = !out_vld_r || out_ready;
  assign c_rdy    = !c_vld_r || d_rdy;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stream state: field position, box fields, running best score
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]  fp_r, fp_nxt;
  logic [PRED_W-1:0] pc_r, pc_nxt;
  logic [VW-1:0]     cx_r, cx_nxt, cy_r, cy_nxt, w_r, w_nxt, h_r, h_nxt;
  logic [VW-1:0]     best_score_r, best_score_nxt;
  logic [POS_W-1:0]  best_class_r, best_class_nxt;

  logic              score_hi;
  logic [VW-1:0]     score_fin;
  logic [POS_W-1:0]  class_fin;
  logic              pred_last;
  logic              pred_emit;

  // best score including the value on the input
  assign score_hi  = in_value > best_score_r;
  assign score_fin = score_hi ? in_value : best_score_r;
  assign class_fin = score_hi ? (fp_r - FP_SCORE) : best_class_r;
  assign pred_last = (fp_r >= FP_SCORE) && (fp_r >= ncls + POS_W'(3));
  assign pred_emit = pred_last && (score_fin >= thr_r);

  always_comb begin
    fp_nxt         = fp_r;
    pc_nxt         = pc_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    if (in_xfer) begin
      case (fp_r)
        FP_CX: begin
          cx_nxt = in_value;
          fp_nxt = FP_CY;
        end
        FP_CY: begin
          cy_nxt = in_value;
          fp_nxt = FP_W;
        end
        FP_W: begin
          w_nxt  = in_value;
          fp_nxt = FP_H;
        end
        FP_H: begin
          h_nxt  = in_value;
          fp_nxt = FP_SCORE;
        end
        default: begin
          if (pred_last) begin
            fp_nxt         = FP_CX;
            best_score_nxt = '0;
            best_class_nxt = '0;
            pc_nxt         = (pc_r == PRED_W'(MAX_PREDS - 1)) ? '0 : pc_r + 1'b1;
          end else begin
            fp_nxt         = fp_r + 1'b1;
            best_score_nxt = score_fin;
            best_class_nxt = class_fin;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r         <= '0;
      pc_r         <= '0;
      cx_r         <= '0;
      cy_r         <= '0;
      w_r          <= '0;
      h_r          <= '0;
      best_score_r <= '0;
      best_class_r <= '0;
    end else begin
      fp_r         <= fp_nxt;
      pc_r         <= pc_nxt;
      cx_r         <= cx_nxt;
      cy_r         <= cy_nxt;
      w_r          <= w_nxt;
      h_r          <= h_nxt;
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: finished prediction, corner numerators 2*c - s - 32*pad
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0]                  a_num_x_r, a_num_y_r;
  logic [VW-1:0]                         a_w_r, a_h_r, a_score_r;
  logic [dhd_pkg::CLASS_ID_W-1:0]        a_class_r;
  logic [dhd_pkg::PRED_INDEX_W-1:0]      a_idx_r;
  logic signed [NW-1:0]                  num_x_nxt, num_y_nxt;
  logic                                  a_vld_nxt;

  // true value lies within the signed 18-bit range, so wrapping arithmetic is exact
  assign num_x_nxt = $signed(NW'({cx_r, 1'b0}) - NW'(w_r) - NW'({pad_left_r, 5'b0}));
  assign num_y_nxt = $signed(NW'({cy_r, 1'b0}) - NW'(h_r) - NW'({pad_top_r, 5'b0}));
  assign a_vld_nxt = a_rdy ? (in_xfer && pred_emit) : a_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_num_x_r <= num_x_nxt;
      a_num_y_r <= num_y_nxt;
      a_w_r     <= w_r;
      a_h_r     <= h_r;
      a_score_r <= score_fin;
      a_class_r <= dhd_pkg::CLASS_ID_W'(class_fin);
      a_idx_r   <= dhd_pkg::PRED_INDEX_W'(pc_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: scale by the reciprocal letterbox factor (units of 2^-21 pixel)
  // ---------------------------------------------------------------------------
  logic signed [LW-1:0]             b_lo_x_r, b_lo_y_r;
  logic [EW-1:0]                    b_ext_x_r, b_ext_y_r;
  logic [VW-1:0]                    b_score_r;
  logic [dhd_pkg::CLASS_ID_W-1:0]   b_class_r;
  logic [dhd_pkg::PRED_INDEX_W-1:0] b_idx_r;
  logic signed [LW:0]               prod_x, prod_y;
  logic [EW-1:0]                    ext_x_nxt, ext_y_nxt;
  logic signed [dhd_pkg::INV_SCALE_W:0] inv_s;
  logic                             b_vld_nxt;

  assign inv_s     = $signed({1'b0, inv_scale_r});
  assign prod_x    = a_num_x_r * inv_s;
  assign prod_y    = a_num_y_r * inv_s;
  assign ext_x_nxt = EW'({a_w_r, 1'b0}) * EW'(inv_scale_r);
  assign ext_y_nxt = EW'({a_h_r, 1'b0}) * EW'(inv_scale_r);
  assign b_vld_nxt = b_rdy ? a_vld_r : b_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_lo_x_r  <= prod_x[LW-1:0];
      b_lo_y_r  <= prod_y[LW-1:0];
      b_ext_x_r <= ext_x_nxt;
      b_ext_y_r <= ext_y_nxt;
      b_score_r <= a_score_r;
      b_class_r <= a_class_r;
      b_idx_r   <= a_idx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: clamp the corner to [0, (lim-1) * 2^21]
  // ---------------------------------------------------------------------------
  function automatic logic [CW-1:0] clamp_corner(input logic signed [LW-1:0] lo,
                                                 input logic [IW-1:0] lim);
    logic [CW-1:0] hi;
    logic [CW-1:0] r;
    hi = {12'(lim - 1'b1), {FB{1'b0}}};
    if (lo[LW-1]) begin
      r = '0;
    end else if (lo > $signed(LW'(hi))) begin
      r = hi;
    end else begin
      r = lo[CW-1:0];
    end
    return r;
  endfunction

  logic [CW-1:0]                    c_loc_x_r, c_loc_y_r;
  logic [EW-1:0]                    c_ext_x_r, c_ext_y_r;
  logic [VW-1:0]                    c_score_r;
  logic [dhd_pkg::CLASS_ID_W-1:0]   c_class_r;
  logic [dhd_pkg::PRED_INDEX_W-1:0] c_idx_r;
  logic                             c_vld_nxt;

  assign c_vld_nxt = c_rdy ? b_vld_r : c_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= c_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_loc_x_r <= clamp_corner(b_lo_x_r, lim_x);
      c_loc_y_r <= clamp_corner(b_lo_y_r, lim_y);
      c_ext_x_r <= b_ext_x_r;
      c_ext_y_r <= b_ext_y_r;
      c_score_r <= b_score_r;
      c_class_r <= b_class_r;
      c_idx_r   <= b_idx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: limit size to the room left past the corner, truncate
  // ---------------------------------------------------------------------------
  function automatic logic [RW-1:0] limit_size(input logic [EW-1:0] ext,
                                               input logic [CW-1:0] loc,
                                               input logic [IW-1:0] lim);
    logic [RW-1:0] room;
    logic [RW-1:0] r;
    room = {lim, {FB{1'b0}}} - RW'(loc);
    if (ext > EW'(room)) begin
      r = room;
    end else begin
      r = ext[RW-1:0];
    end
    return r;
  endfunction

  logic [RW-1:0] size_x, size_y;
  logic          out_vld_nxt;

  assign size_x      = limit_size(c_ext_x_r, c_loc_x_r, lim_x);
  assign size_y      = limit_size(c_ext_y_r, c_loc_y_r, lim_y);
  assign out_vld_nxt = d_rdy ? c_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy) begin
      out_box_x      <= c_loc_x_r[CW-1:FB];
      out_box_y      <= c_loc_y_r[CW-1:FB];
      out_box_width  <= size_x[RW-1:FB];
      out_box_height <= size_y[RW-1:FB];
      out_score      <= c_score_r;
      out_class_id   <= c_class_r;
      out_pred_index <= c_idx_r;
    end
  end

  assign out_valid = out_vld_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // field position never runs past the longest possible prediction
  a_fp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fp_r) <= MAX_CLASSES + 3)
    else $error("field position out of range");

  // the last score of a prediction restarts the row and clears the running best
  a_pred_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && pred_last) |=> (fp_r == FP_CX && best_score_r == '0 && best_class_r == '0))
    else $error("prediction did not restart");

  // a stalled prediction register holds its contents
  a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !b_rdy) |=> (a_vld_r && $stable(a_score_r) && $stable(a_idx_r)))
    else $error("stage A lost data under stall");

  // with the sink ready, the stream is never stalled
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");
`endif

endmodule

>>> tb/tb.sv
// tb: self-checking bench for detection_head_decode_top (box decode with letterbox undo).
// Depends on dhd_pkg and the block's RTL; builds its own decoder model and score tracker.
`timescale 1ns / 1ps

module tb;

  // Local copies of the package sizes and reset values
  localparam int VALUE_W         = dhd_pkg::VALUE_W;
  localparam int BOX_XY_W        = dhd_pkg::BOX_XY_W;
  localparam int BOX_WH_W        = dhd_pkg::BOX_WH_W;
  localparam int SCORE_W         = dhd_pkg::SCORE_W;
  localparam int CLASS_ID_W      = dhd_pkg::CLASS_ID_W;
  localparam int PRED_INDEX_W    = dhd_pkg::PRED_INDEX_W;
  localparam int THR_W           = dhd_pkg::THR_W;
  localparam int PAD_W           = dhd_pkg::PAD_W;
  localparam int INV_SCALE_W     = dhd_pkg::INV_SCALE_W;
  localparam int IMG_W           = dhd_pkg::IMG_W;
  localparam int CLS_CNT_W       = dhd_pkg::CLS_CNT_W;
  localparam int CFG_INDEX_W     = dhd_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W      = dhd_pkg::CFG_DATA_W;
  localparam int FRAC_BITS       = dhd_pkg::FRAC_BITS;
  localparam int MAX_CLASSES_DEF = dhd_pkg::MAX_CLASSES_DEF;
  localparam int MAX_PREDS_DEF   = dhd_pkg::MAX_PREDS_DEF;
  localparam logic [THR_W-1:0]       THR_RST       = dhd_pkg::THR_RST;
  localparam logic [PAD_W-1:0]       PAD_RST       = dhd_pkg::PAD_RST;
  localparam logic [INV_SCALE_W-1:0] INV_SCALE_RST = dhd_pkg::INV_SCALE_RST;
  localparam logic [IMG_W-1:0]       IMG_SIZE_RST  = dhd_pkg::IMG_SIZE_RST;
  localparam logic [CLS_CNT_W-1:0]   CLS_CNT_RST   = dhd_pkg::CLS_CNT_RST;
  localparam int unsigned THR_DEF = 32'(dhd_pkg::THR_RST);
  localparam int unsigned INV_DEF = 32'(dhd_pkg::INV_SCALE_RST);
  localparam int unsigned IMG_DEF = 32'(dhd_pkg::IMG_SIZE_RST);

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;     // margin for the output pipeline to drain
  localparam int MAX_REPORTS    = 10;
  localparam int IMG_LIMIT      = 4096;
  localparam longint PIXEL_ONE  = longint'(1) << FRAC_BITS;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [BOX_XY_W-1:0]     bx;
    logic [BOX_XY_W-1:0]     by;
    logic [BOX_WH_W-1:0]     bw;
    logic [BOX_WH_W-1:0]     bh;
    logic [SCORE_W-1:0]      score;
    logic [CLASS_ID_W-1:0]   cls;
    logic [PRED_INDEX_W-1:0] idx;
  } box_t;

  typedef struct packed {
    logic [BOX_XY_W-1:0] corner;
    logic [BOX_WH_W-1:0] span;
  } axis_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic in_valid;
  logic in_ready;
  logic [VALUE_W-1:0] in_value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BOX_XY_W-1:0]     out_box_x;
  logic [BOX_XY_W-1:0]     out_box_y;
  logic [BOX_WH_W-1:0]     out_box_width;
  logic [BOX_WH_W-1:0]     out_box_height;
  logic [SCORE_W-1:0]      out_score;
  logic [CLASS_ID_W-1:0]   out_class_id;
  logic [PRED_INDEX_W-1:0] out_pred_index;

  // Shadow copy of the register file
  logic [THR_W-1:0]       thr_r     = THR_RST;
  logic [PAD_W-1:0]       pad_l_r   = PAD_RST;
  logic [PAD_W-1:0]       pad_t_r   = PAD_RST;
  logic [INV_SCALE_W-1:0] inv_r     = INV_SCALE_RST;
  logic [IMG_W-1:0]       img_w_r   = IMG_SIZE_RST;
  logic [IMG_W-1:0]       img_h_r   = IMG_SIZE_RST;
  logic [CLS_CNT_W-1:0]   cls_cnt_r = CLS_CNT_RST;

  // Decoder state as the block should hold it
  int unsigned field_pos = 0;
  int unsigned pred_seq  = 0;
  logic [VALUE_W-1:0] cx_q = '0, cy_q = '0, w_q = '0, h_q = '0;
  logic [SCORE_W-1:0] top_score = '0;
  int unsigned top_class = 0;

  box_t boxes_due[$];
  box_t due_box;

  bit gaps_on;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int shown = 0;
  int values_sent = 0;
  int preds_done = 0;
  int boxes_checked = 0;
  int reg_writes = 0;

  detection_head_decode_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_box_x      (out_box_x),
    .out_box_y      (out_box_y),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .out_score      (out_score),
    .out_class_id   (out_class_id),
    .out_pred_index (out_pred_index)
  );

  always #1 clk = ~clk;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One axis of the letterbox undo, all in 2^-21 pixel units until the final shift
  function automatic axis_t decode_axis(logic [VALUE_W-1:0] c, logic [VALUE_W-1:0] s,
                                        logic [PAD_W-1:0] pad, int unsigned lim);
    longint num, lo, ext, hi, room;
    axis_t a;
    num = 2 * longint'(c) - longint'(s) - 32 * longint'(pad);
    lo = num * longint'(inv_r);
    ext = 2 * longint'(s) * longint'(inv_r);
    hi = (longint'(lim) - 1) * PIXEL_ONE;
    if (lo < 0) lo = 0;
    if (lo > hi) lo = hi;
    room = longint'(lim) * PIXEL_ONE - lo;
    if (ext > room) ext = room;
    a.corner = BOX_XY_W'(lo >> FRAC_BITS);
    a.span = BOX_WH_W'(ext >> FRAC_BITS);
    return a;
  endfunction

  // Advance the decoder state by one accepted value; queue a box when one is due
  task automatic decode_value(input logic [VALUE_W-1:0] v);
    int unsigned ncls;
    axis_t ax, ay;
    box_t b;
    ncls = clip(32'(cls_cnt_r), 1, MAX_CLASSES_DEF);
    if (field_pos < 4) begin
      case (field_pos)
        0: cx_q = v;
        1: cy_q = v;
        2: w_q = v;
        default: h_q = v;
      endcase
      field_pos++;
    end else begin
      if (v > top_score) begin
        top_score = v;
        top_class = field_pos - 4;
      end
      if (field_pos < 3 + ncls) begin
        field_pos++;
      end else begin
        if (top_score >= thr_r) begin
          ax = decode_axis(cx_q, w_q, pad_l_r, clip(32'(img_w_r), 1, IMG_LIMIT));
          ay = decode_axis(cy_q, h_q, pad_t_r, clip(32'(img_h_r), 1, IMG_LIMIT));
          b.bx = ax.corner;
          b.bw = ax.span;
          b.by = ay.corner;
          b.bh = ay.span;
          b.score = top_score;
          b.cls = CLASS_ID_W'(top_class);
          b.idx = PRED_INDEX_W'(pred_seq);
          boxes_due = {boxes_due, b};
        end
        field_pos = 0;
        top_score = '0;
        top_class = 0;
        pred_seq = (pred_seq + 1) % MAX_PREDS_DEF;
        preds_done++;
      end
    end
  endtask

  // One value transfer; an optional gap goes in front of it
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int unsigned gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    do @(posedge clk); while (in_ready !== 1'b1);
    decode_value(v);
    values_sent++;
  endtask

  // Stop sending and wait until every queued box has come out and the pipe is empty
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
    case (idx)
      dhd_pkg::REG_SCORE_THRESHOLD: thr_r = data[THR_W-1:0];
      dhd_pkg::REG_PAD_LEFT:        pad_l_r = data[PAD_W-1:0];
      dhd_pkg::REG_PAD_TOP:         pad_t_r = data[PAD_W-1:0];
      dhd_pkg::REG_INV_SCALE:       inv_r = data[INV_SCALE_W-1:0];
      dhd_pkg::REG_IMAGE_WIDTH:     img_w_r = data[IMG_W-1:0];
      dhd_pkg::REG_IMAGE_HEIGHT:    img_h_r = data[IMG_W-1:0];
      dhd_pkg::REG_CLASS_COUNT:     cls_cnt_r = data[CLS_CNT_W-1:0];
      default: ;  // unmapped index, write dropped
    endcase
  endtask

  task automatic program_all(input int unsigned thr, pl, pt, inv, iw, ih, cc);
    quiesce();
    write_reg(dhd_pkg::REG_SCORE_THRESHOLD, thr);
    write_reg(dhd_pkg::REG_PAD_LEFT, pl);
    write_reg(dhd_pkg::REG_PAD_TOP, pt);
    write_reg(dhd_pkg::REG_INV_SCALE, inv);
    write_reg(dhd_pkg::REG_IMAGE_WIDTH, iw);
    write_reg(dhd_pkg::REG_IMAGE_HEIGHT, ih);
    write_reg(dhd_pkg::REG_CLASS_COUNT, cc);
  endtask

  task automatic send_box(input logic [VALUE_W-1:0] cx, cy, w, h);
    send_value(cx);
    send_value(cy);
    send_value(w);
    send_value(h);
  endtask

  // Random prediction: box fields of mixed style, scores biased toward ties,
  // zeros, full scale and the threshold edges
  task automatic send_prediction();
    int unsigned ncls, style, pick;
    logic [VALUE_W-1:0] fld, sc, last;
    ncls = clip(32'(cls_cnt_r), 1, MAX_CLASSES_DEF);
    style = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      if (style == 0) fld = VALUE_W'($urandom);
      else if (style == 1) fld = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else if (i < 2) fld = VALUE_W'($urandom_range(0, 10240));
      else fld = VALUE_W'($urandom_range(0, 6400));
      send_value(fld);
    end
    last = '0;
    repeat (ncls) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: sc = '0;
        1: sc = 16'hFFFF;
        2: sc = last;
        3: sc = thr_r;
        4: sc = thr_r - 1'b1;
        default: sc = VALUE_W'($urandom);
      endcase
      send_value(sc);
      last = sc;
    end
  endtask

  task automatic run_predictions(input int quota);
    int stop_at;
    stop_at = values_sent + quota;
    while (values_sent < stop_at) begin
      send_prediction();
      // now and then hold the stream until every box is out
      if (gaps_on && $urandom_range(0, 24) == 0) quiesce();
    end
  endtask

  // Threshold is inclusive; largest fields clamp against the image
  task automatic test_threshold_edges();
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_value(THR_RST);
    send_box('0, '0, '0, '0);
    send_value(THR_RST - 1'b1);
  endtask

  // All-zero row reports class 0; a tie keeps the earlier class
  task automatic test_ties_and_zero_row();
    quiesce();
    write_reg(dhd_pkg::REG_CLASS_COUNT, 2);
    write_reg(dhd_pkg::REG_SCORE_THRESHOLD, 0);
    send_box(16'd5120, 16'd5120, 16'd1600, 16'd800);
    send_value('0);
    send_value('0);
    send_box(16'd1000, 16'd9000, 16'd3000, 16'd200);
    send_value(16'h1234);
    send_value(16'h1234);
  endtask

  // Saturated image size and class count, unmapped index, zero inverse scale
  task automatic test_register_corners();
    quiesce();
    write_reg(REG_UNUSED, '1);
    write_reg(dhd_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(dhd_pkg::REG_IMAGE_HEIGHT, 'h1FFF);
    write_reg(dhd_pkg::REG_CLASS_COUNT, 0);
    write_reg(dhd_pkg::REG_PAD_LEFT, 'h7FF);
    write_reg(dhd_pkg::REG_PAD_TOP, 'h7FF);
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_value(16'hFFFF);
    quiesce();
    write_reg(dhd_pkg::REG_INV_SCALE, 0);
    send_box(16'd8000, 16'd6000, 16'd4000, 16'd2000);
    send_value(16'h8000);
  endtask

  // Class count lowered while a prediction is half done: next score closes it
  task automatic test_class_count_change();
    program_all(0, 0, 0, INV_DEF, IMG_DEF, IMG_DEF, 3);
    send_box(16'd4000, 16'd4000, 16'd800, 16'd800);
    send_value(16'd10);
    send_value(16'd20);
    quiesce();
    write_reg(dhd_pkg::REG_CLASS_COUNT, 1);
    send_value(16'd30);
  endtask

  // Fixed settings, the extremes among them
  task automatic test_fixed_settings();
    program_all(THR_DEF, 0, 0, INV_DEF, IMG_DEF, IMG_DEF, 1);
    run_predictions(120);
    program_all('h8000, 80, 0, 'h18000, 1280, 720, 8);
    run_predictions(120);
    program_all(0, 'h7FF, 'h7FF, 'hFFFFFF, 4096, 4096, 3);
    run_predictions(120);
    program_all('hFFFF, 0, 0, 1, 1, 1, 2);
    run_predictions(120);
  endtask

  task automatic test_random_registers();
    int unsigned inv, iw, ih;
    repeat (4) begin
      inv = $urandom_range(0, 1) ? $urandom : $urandom_range(32768, 196608);
      iw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      ih = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      program_all($urandom_range(0, 65535), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), inv, iw, ih, $urandom_range(0, 12));
      run_predictions(40);
    end
  endtask

  // Closing stretch: values back to back, sink always ready, every prediction emitting
  task automatic test_back_to_back();
    program_all(0, 0, 0, INV_DEF, IMG_DEF, IMG_DEF, 1);
    gaps_on = 1'b0;
    run_predictions(100);
  endtask

  // Result stall bursts
  always @(negedge clk) begin
    if (stall_left == 0 && gaps_on && $urandom_range(0, 11) == 0)
      stall_left = $urandom_range(1, 11);
    out_ready = (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  // Result check against the oldest expected box
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      boxes_checked++;
      if (boxes_due.size() == 0) begin
        errors++;
        if (shown < MAX_REPORTS) begin
          $display("unexpected box: x=%0d y=%0d w=%0d h=%0d score=%0d class=%0d idx=%0d",
                   out_box_x, out_box_y, out_box_width, out_box_height, out_score,
                   out_class_id, out_pred_index);
          shown++;
        end
      end else begin
        due_box = boxes_due.pop_front();
        if (out_box_x !== due_box.bx || out_box_y !== due_box.by ||
            out_box_width !== due_box.bw || out_box_height !== due_box.bh ||
            out_score !== due_box.score || out_class_id !== due_box.cls ||
            out_pred_index !== due_box.idx) begin
          errors++;
          if (shown < MAX_REPORTS) begin
            $display("box mismatch: expected x=%0d y=%0d w=%0d h=%0d score=%0d class=%0d idx=%0d",
                     due_box.bx, due_box.by, due_box.bw, due_box.bh, due_box.score,
                     due_box.cls, due_box.idx);
            $display("              got      x=%0d y=%0d w=%0d h=%0d score=%0d class=%0d idx=%0d",
                     out_box_x, out_box_y, out_box_width, out_box_height, out_score,
                     out_class_id, out_pred_index);
            shown++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, %0d boxes outstanding", quiet_cycles,
                 boxes_due.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dhd_pkg::REG_SCORE_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    in_value = '0;
    gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_threshold_edges();
    test_ties_and_zero_row();
    test_register_corners();
    test_class_count_change();
    test_fixed_settings();
    test_random_registers();
    // closing stretch runs without idling on either side
    test_back_to_back();
    quiesce();

    $display("Sent %0d values in %0d predictions, %0d register writes.",
             values_sent, preds_done, reg_writes);
    $display("Checked %0d boxes, %0d errors.", boxes_checked, errors);
    if (errors == 0 && boxes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
